// File: sv/lups_pkg.sv
package lups_pkg;

    localparam int IDX_MAX_W = 6;

    localparam logic [1:0] FN_MAT   = 2'd0;
    localparam logic [1:0] FN_RHS   = 2'd1;
    localparam logic [1:0] FN_SOLVE = 2'd2;

    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_PERM_INIT = 5'd2;
    localparam logic [4:0] OP_SRCH_CMP  = 5'd3;
    localparam logic [4:0] OP_SWAP      = 5'd4;
    localparam logic [4:0] OP_PIV       = 5'd5;
    localparam logic [4:0] OP_LDIV      = 5'd6;
    localparam logic [4:0] OP_LSTORE    = 5'd7;
    localparam logic [4:0] OP_UCAP      = 5'd8;
    localparam logic [4:0] OP_UMUL      = 5'd9;
    localparam logic [4:0] OP_UWR       = 5'd10;
    localparam logic [4:0] OP_FINAL     = 5'd11;
    localparam logic [4:0] OP_FINIT     = 5'd12;
    localparam logic [4:0] OP_MULY      = 5'd13;
    localparam logic [4:0] OP_ACCSUB    = 5'd14;
    localparam logic [4:0] OP_YST       = 5'd15;
    localparam logic [4:0] OP_BINIT     = 5'd16;
    localparam logic [4:0] OP_BDIV      = 5'd17;
    localparam logic [4:0] OP_BST       = 5'd18;
    localparam logic [4:0] OP_EMIT      = 5'd19;

    typedef struct packed {
        logic [4:0]           op;
        logic                 rd;
        logic                 flag;
        logic [IDX_MAX_W-1:0] r;
        logic [IDX_MAX_W-1:0] c;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic signed [31:0] sat_prod(input logic signed [63:0] p);
        logic signed [47:0] s;
        s = p[63:16];
        if (s > 48'sh0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < 48'shFFFF_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        if (d[32] != d[31])
            return d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            return d[31:0];
    endfunction

endpackage

// File: sv/lups_ram.sv
module lups_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lups_div.sv
module lups_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic               done,
    output logic signed [31:0] q
);

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic [5:0]         cnt_reg;
    logic [32:0]        rem_reg;
    logic [47:0]        dvd_reg;
    logic [47:0]        quo_reg;
    logic [31:0]        dmag_reg;
    logic               neg_reg;
    logic signed [31:0] q_reg;
    logic [32:0]        rem_sh;
    logic [31:0]        amag;
    logic [31:0]        bmag;

    assign amag   = a[31] ? 32'(-a) : 32'(a);
    assign bmag   = b[31] ? 32'(-b) : 32'(b);
    assign rem_sh = {rem_reg[31:0], dvd_reg[47]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start)
            begin
                if (b == 32'sd0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg && cnt_reg == 6'd0)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= {amag, 16'd0};
            rem_reg  <= 33'd0;
            quo_reg  <= 48'd0;
            dmag_reg <= bmag;
            neg_reg  <= a[31] ^ b[31];
            cnt_reg  <= 6'd47;
            if (b == 32'sd0)
            begin
                q_reg <= (a > 32'sd0) ? 32'sh7FFF_FFFF :
                         (a < 32'sd0) ? 32'sh8000_0000 : 32'sd0;
            end
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[46:0], 1'b0};
            cnt_reg <= cnt_reg - 6'd1;
            if (rem_sh >= {1'b0, dmag_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dmag_reg};
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
        else if (fin_reg)
        begin
            if (neg_reg)
            begin
                q_reg <= (quo_reg > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                        : 32'(-quo_reg[31:0]);
            end
            else
            begin
                q_reg <= (quo_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                        : 32'(quo_reg[31:0]);
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// File: sv/lups_dp.sv
module lups_dp #(
    parameter int MAX_ORDER = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lups_pkg::dp_cmd_t    cmd,
    output lups_pkg::dp_stat_t   stat,
    input  logic [1:0]           func,
    input  logic [2:0]           row_index,
    input  logic [2:0]           col_index,
    input  logic signed [31:0]   element_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           sol_index,
    output logic signed [31:0]   sol_value,
    output logic                 singular,
    output logic                 last
);

    localparam int IW     = $clog2(MAX_ORDER);
    localparam int RDEPTH = 1 << (2 * IW);

    logic [IW-1:0]      perm_reg [MAX_ORDER];
    logic signed [31:0] rhs_reg [MAX_ORDER];
    logic signed [31:0] y_reg [MAX_ORDER];
    logic signed [31:0] acc_reg;
    logic signed [31:0] tmp_reg;
    logic signed [31:0] piv_reg;
    logic signed [31:0] l_reg;
    logic signed [63:0] prod_reg;
    logic [32:0]        bestmag_reg;
    logic [IW-1:0]      best_reg;
    logic               sing_reg;
    logic               valid_reg;
    logic [2:0]         idx_reg;
    logic signed [31:0] val_reg;
    logic               last_reg;
    logic               sing_out_reg;

    logic [IW-1:0]      r;
    logic [IW-1:0]      c;
    logic [2*IW-1:0]    addr;
    logic               ram_we;
    logic [2*IW-1:0]    ram_waddr;
    logic signed [31:0] ram_wdata;
    logic signed [31:0] rd_data;
    logic [32:0]        mag;
    logic               load_mat;
    logic               div_start;
    logic signed [31:0] div_a;
    logic signed [31:0] div_b;
    logic               div_done;
    logic signed [31:0] div_q;

    assign r    = cmd.r[IW-1:0];
    assign c    = cmd.c[IW-1:0];
    assign addr = {perm_reg[r], c};
    assign mag  = rd_data[31] ? 33'(-$signed({rd_data[31], rd_data}))
                              : {1'b0, rd_data};

    assign load_mat = cmd.op == lups_pkg::OP_LOAD && func == lups_pkg::FN_MAT
                      && 32'(row_index) < MAX_ORDER && 32'(col_index) < MAX_ORDER;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr;
        ram_wdata = element_value;
        case (cmd.op)
            lups_pkg::OP_LOAD:
            begin
                ram_we    = load_mat;
                ram_waddr = {IW'(row_index), IW'(col_index)};
            end
            lups_pkg::OP_LSTORE:
            begin
                ram_we    = 1'b1;
                ram_wdata = div_q;
            end
            lups_pkg::OP_UWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = lups_pkg::sat_sub(acc_reg, lups_pkg::sat_prod(prod_reg));
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    lups_ram #(
        .WIDTH (32),
        .DEPTH (RDEPTH)
    ) u_mat (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (addr),
        .rdata (rd_data)
    );

    assign div_start = cmd.op == lups_pkg::OP_LDIV || cmd.op == lups_pkg::OP_BDIV;
    assign div_a     = (cmd.op == lups_pkg::OP_LDIV) ? rd_data : acc_reg;
    assign div_b     = (cmd.op == lups_pkg::OP_LDIV) ? piv_reg : rd_data;

    lups_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == lups_pkg::OP_EMIT)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.op == lups_pkg::OP_PERM_INIT)
            begin
                sing_reg <= 1'b0;
            end
            else if ((cmd.op == lups_pkg::OP_PIV || cmd.op == lups_pkg::OP_FINAL)
                     && rd_data == 32'sd0)
            begin
                sing_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            lups_pkg::OP_LOAD:
            begin
                if (func == lups_pkg::FN_RHS && 32'(row_index) < MAX_ORDER)
                begin
                    rhs_reg[IW'(row_index)] <= element_value;
                end
            end
            lups_pkg::OP_PERM_INIT:
            begin
                for (int x = 0; x < MAX_ORDER; x++)
                begin
                    perm_reg[x] <= IW'(x);
                end
            end
            lups_pkg::OP_SRCH_CMP:
            begin
                if (cmd.flag || mag > bestmag_reg)
                begin
                    bestmag_reg <= mag;
                    best_reg    <= r;
                end
            end
            lups_pkg::OP_SWAP:
            begin
                if (best_reg != r)
                begin
                    perm_reg[r]        <= perm_reg[best_reg];
                    perm_reg[best_reg] <= perm_reg[r];
                end
            end
            lups_pkg::OP_PIV:
            begin
                piv_reg <= rd_data;
            end
            lups_pkg::OP_LSTORE:
            begin
                l_reg <= div_q;
            end
            lups_pkg::OP_UCAP:
            begin
                tmp_reg <= rd_data;
            end
            lups_pkg::OP_UMUL:
            begin
                acc_reg  <= rd_data;
                prod_reg <= tmp_reg * l_reg;
            end
            lups_pkg::OP_FINIT:
            begin
                acc_reg <= rhs_reg[perm_reg[r]];
            end
            lups_pkg::OP_MULY:
            begin
                prod_reg <= rd_data * y_reg[c];
            end
            lups_pkg::OP_ACCSUB:
            begin
                acc_reg <= lups_pkg::sat_sub(acc_reg, lups_pkg::sat_prod(prod_reg));
            end
            lups_pkg::OP_YST:
            begin
                y_reg[r] <= acc_reg;
            end
            lups_pkg::OP_BINIT:
            begin
                acc_reg <= y_reg[r];
            end
            lups_pkg::OP_BST:
            begin
                y_reg[r] <= div_q;
            end
            lups_pkg::OP_EMIT:
            begin
                idx_reg      <= 3'(r);
                val_reg      <= y_reg[r];
                last_reg     <= cmd.flag;
                sing_out_reg <= sing_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign stat.div_done = div_done;
    assign stat.out_free = !valid_reg || out_ready;
    assign out_valid     = valid_reg;
    assign sol_index     = idx_reg;
    assign sol_value     = val_reg;
    assign singular      = sing_out_reg;
    assign last          = last_reg;

endmodule

// File: sv/lups_ctrl.sv
module lups_ctrl #(
    parameter int MAX_ORDER = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [2:0]         row_index,
    input  logic [2:0]         col_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,
    output lups_pkg::dp_cmd_t  cmd,
    input  lups_pkg::dp_stat_t stat
);

    localparam int CW = $clog2(MAX_ORDER + 1) + 1;
    localparam int XW = lups_pkg::IDX_MAX_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_INIT  = 5'd1;
    localparam logic [4:0] S_SRD   = 5'd2;
    localparam logic [4:0] S_SCMP  = 5'd3;
    localparam logic [4:0] S_SWAP  = 5'd4;
    localparam logic [4:0] S_PRD   = 5'd5;
    localparam logic [4:0] S_PLD   = 5'd6;
    localparam logic [4:0] S_LRD   = 5'd7;
    localparam logic [4:0] S_LDIV  = 5'd8;
    localparam logic [4:0] S_LWAIT = 5'd9;
    localparam logic [4:0] S_URA   = 5'd10;
    localparam logic [4:0] S_URB   = 5'd11;
    localparam logic [4:0] S_UMUL  = 5'd12;
    localparam logic [4:0] S_UWR   = 5'd13;
    localparam logic [4:0] S_DRD   = 5'd14;
    localparam logic [4:0] S_DCHK  = 5'd15;
    localparam logic [4:0] S_FINIT = 5'd16;
    localparam logic [4:0] S_FRD   = 5'd17;
    localparam logic [4:0] S_FMUL  = 5'd18;
    localparam logic [4:0] S_FSUB  = 5'd19;
    localparam logic [4:0] S_FST   = 5'd20;
    localparam logic [4:0] S_BINIT = 5'd21;
    localparam logic [4:0] S_BRD   = 5'd22;
    localparam logic [4:0] S_BMUL  = 5'd23;
    localparam logic [4:0] S_BSUB  = 5'd24;
    localparam logic [4:0] S_BDRD  = 5'd25;
    localparam logic [4:0] S_BDIV  = 5'd26;
    localparam logic [4:0] S_BWAIT = 5'd27;
    localparam logic [4:0] S_EMIT  = 5'd28;

    logic [4:0]    state_reg;
    logic [4:0]    state_next;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_next;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] k_next;
    logic [3:0]    size_reg;
    logic          fact_reg;
    logic          fact_next;
    logic [CW-1:0] n;
    logic          accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == S_IDLE;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (size_reg == 4'd0)
            n = CW'(1);
        else if (32'(size_reg) > MAX_ORDER)
            n = CW'(MAX_ORDER);
        else
            n = CW'(size_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        fact_next  = fact_reg;
        cmd        = '0;
        cmd.op     = lups_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = lups_pkg::OP_LOAD;
                    if (func == lups_pkg::FN_MAT && 32'(row_index) < MAX_ORDER
                        && 32'(col_index) < MAX_ORDER)
                    begin
                        fact_next = 1'b0;
                    end
                    if (func == lups_pkg::FN_SOLVE)
                    begin
                        i_next     = '0;
                        state_next = fact_reg ? S_FINIT : S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = lups_pkg::OP_PERM_INIT;
                i_next     = '0;
                k_next     = '0;
                state_next = (n == CW'(1)) ? S_DRD : S_SRD;
            end
            S_SRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(k_reg);
                cmd.c      = XW'(i_reg);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.op   = lups_pkg::OP_SRCH_CMP;
                cmd.r    = XW'(k_reg);
                cmd.flag = k_reg == i_reg;
                k_next   = k_reg + CW'(1);
                state_next = (k_reg + CW'(1) < n) ? S_SRD : S_SWAP;
            end
            S_SWAP:
            begin
                cmd.op     = lups_pkg::OP_SWAP;
                cmd.r      = XW'(i_reg);
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(i_reg);
                cmd.c      = XW'(i_reg);
                state_next = S_PLD;
            end
            S_PLD:
            begin
                cmd.op     = lups_pkg::OP_PIV;
                j_next     = i_reg + CW'(1);
                state_next = S_LRD;
            end
            S_LRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(j_reg);
                cmd.c      = XW'(i_reg);
                state_next = S_LDIV;
            end
            S_LDIV:
            begin
                cmd.op     = lups_pkg::OP_LDIV;
                state_next = S_LWAIT;
            end
            S_LWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = lups_pkg::OP_LSTORE;
                    cmd.r      = XW'(j_reg);
                    cmd.c      = XW'(i_reg);
                    k_next     = i_reg + CW'(1);
                    state_next = S_URA;
                end
            end
            S_URA:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(i_reg);
                cmd.c      = XW'(k_reg);
                state_next = S_URB;
            end
            S_URB:
            begin
                cmd.op     = lups_pkg::OP_UCAP;
                cmd.rd     = 1'b1;
                cmd.r      = XW'(j_reg);
                cmd.c      = XW'(k_reg);
                state_next = S_UMUL;
            end
            S_UMUL:
            begin
                cmd.op     = lups_pkg::OP_UMUL;
                state_next = S_UWR;
            end
            S_UWR:
            begin
                cmd.op = lups_pkg::OP_UWR;
                cmd.r  = XW'(j_reg);
                cmd.c  = XW'(k_reg);
                if (k_reg + CW'(1) < n)
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_URA;
                end
                else if (j_reg + CW'(1) < n)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_LRD;
                end
                else if (i_reg + CW'(2) < n)
                begin
                    i_next     = i_reg + CW'(1);
                    k_next     = i_reg + CW'(1);
                    state_next = S_SRD;
                end
                else
                begin
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(n - CW'(1));
                cmd.c      = XW'(n - CW'(1));
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                cmd.op     = lups_pkg::OP_FINAL;
                fact_next  = 1'b1;
                i_next     = '0;
                state_next = S_FINIT;
            end
            S_FINIT:
            begin
                cmd.op     = lups_pkg::OP_FINIT;
                cmd.r      = XW'(i_reg);
                k_next     = '0;
                state_next = (i_reg == '0) ? S_FST : S_FRD;
            end
            S_FRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(i_reg);
                cmd.c      = XW'(k_reg);
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cmd.op     = lups_pkg::OP_MULY;
                cmd.c      = XW'(k_reg);
                state_next = S_FSUB;
            end
            S_FSUB:
            begin
                cmd.op = lups_pkg::OP_ACCSUB;
                k_next = k_reg + CW'(1);
                state_next = (k_reg + CW'(1) < i_reg) ? S_FRD : S_FST;
            end
            S_FST:
            begin
                cmd.op = lups_pkg::OP_YST;
                cmd.r  = XW'(i_reg);
                if (i_reg + CW'(1) < n)
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_FINIT;
                end
                else
                begin
                    state_next = S_BINIT;
                end
            end
            S_BINIT:
            begin
                cmd.op     = lups_pkg::OP_BINIT;
                cmd.r      = XW'(i_reg);
                k_next     = i_reg + CW'(1);
                state_next = (i_reg + CW'(1) < n) ? S_BRD : S_BDRD;
            end
            S_BRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(i_reg);
                cmd.c      = XW'(k_reg);
                state_next = S_BMUL;
            end
            S_BMUL:
            begin
                cmd.op     = lups_pkg::OP_MULY;
                cmd.c      = XW'(k_reg);
                state_next = S_BSUB;
            end
            S_BSUB:
            begin
                cmd.op = lups_pkg::OP_ACCSUB;
                k_next = k_reg + CW'(1);
                state_next = (k_reg + CW'(1) < n) ? S_BRD : S_BDRD;
            end
            S_BDRD:
            begin
                cmd.rd     = 1'b1;
                cmd.r      = XW'(i_reg);
                cmd.c      = XW'(i_reg);
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                cmd.op     = lups_pkg::OP_BDIV;
                state_next = S_BWAIT;
            end
            S_BWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.op = lups_pkg::OP_BST;
                    cmd.r  = XW'(i_reg);
                    if (i_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next     = i_reg - CW'(1);
                        state_next = S_BINIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op   = lups_pkg::OP_EMIT;
                    cmd.r    = XW'(i_reg);
                    cmd.flag = i_reg + CW'(1) == n;
                    i_next   = i_reg + CW'(1);
                    if (i_reg + CW'(1) == n)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            fact_reg  <= 1'b0;
            size_reg  <= 4'd8;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
                fact_reg <= 1'b0;
            end
            else
            begin
                fact_reg <= fact_next;
            end
        end
    end

endmodule

// File: sv/lu_pivot_linear_solver_core.sv
// Solves A x = b in signed Q16.16 with LU factorization and row pivoting.
// Input transactions on the s_ channel carry a command in s_tuser: load a
// matrix element, load a right-hand-side element, or solve. A load leaves
// the block idle. A solve factorizes the stored matrix only when no current
// factorization exists, then substitutes and emits n solution transactions
// on the m_ channel in index order, tlast on the final one, tuser flagging a
// zero pivot. The order n is set through the cfg_ channel; the user must set
// it only while idle, which the block itself does not enforce. A solve runs
// the elimination (when factorizing) and both substitution passes as
// multiply-subtract steps and divides in the bit-serial divider (n(n-1)/2 + n
// divisions when factorizing, n otherwise). The shared matrix memory port and
// the divider set its running time.
// The block takes no new input until all results have entered the output
// register; a stalled receiver holds that register and pauses emission.
// Reset sets the order to 8 and marks the matrix as not factorized; stored
// elements are undefined until loaded.
module lu_pivot_linear_solver_core #(
    parameter int MAX_ORDER = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_index, col_index, element_value, zero pad
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // sol_index, sol_value, zero pad
    output logic        m_tuser,   // singular
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    lups_pkg::dp_cmd_t  cmd;
    lups_pkg::dp_stat_t stat;
    logic [2:0]         sol_index;
    logic signed [31:0] sol_value;

    lups_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .func      (s_tuser),
        .row_index (s_tdata[2:0]),
        .col_index (s_tdata[5:3]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    lups_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (s_tuser),
        .row_index     (s_tdata[2:0]),
        .col_index     (s_tdata[5:3]),
        .element_value (s_tdata[37:6]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .sol_index     (sol_index),
        .sol_value     (sol_value),
        .singular      (m_tuser),
        .last          (m_tlast)
    );

    assign m_tdata = {5'd0, sol_value, sol_index};

endmodule
